// ===== hw/rtl/indexed_list_engine_top_defines.svh =====
// Assertion macros used by the indexed list engine top level.
`ifndef INDEXED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ile_pkg.sv =====
// Types and constants of the indexed list engine.
package ile_pkg;

   // List geometry.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the request and response transactions.
   localparam int KIND_W = 4;
   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 6;

   // Width wide enough to compare a position against the count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request codes.
   typedef enum logic [KIND_W-1:0] {
      REQ_INS_FRONT  = 4'd0,
      REQ_INS_BACK   = 4'd1,
      REQ_INS_AFTER  = 4'd2,
      REQ_INS_BEFORE = 4'd3,
      REQ_DEL_FRONT  = 4'd4,
      REQ_DEL_BACK   = 4'd5,
      REQ_DEL_AT     = 4'd6,
      REQ_READ_AT    = 4'd7,
      REQ_DUMP       = 4'd8
   } req_kind_type;

   // Response status codes.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // Action broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_INS  = 2'd1,
      CELL_DEL  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          at;
      logic signed [DATA_W-1:0]  value;
   } cell_cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DUMP = 2'b10
   } fsm_type;

endpackage

// ===== hw/rtl/ile_req_if.sv =====
// Request channel of the indexed list engine.
interface ile_req_if;
   logic                              valid;
   logic                              ready;
   logic [ile_pkg::KIND_W-1:0]        req_type;
   logic signed [ile_pkg::DATA_W-1:0] value;
   logic [ile_pkg::POS_W-1:0]         position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink (input valid, input req_type, input value, input position,
                 output ready);
endinterface

// ===== hw/rtl/ile_rsp_if.sv =====
// Response channel of the indexed list engine.
interface ile_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ile_pkg::STAT_W-1:0]        status;
   logic signed [ile_pkg::DATA_W-1:0] data;
   logic [ile_pkg::LEN_W-1:0]         length;
   logic                              last;

   modport source (output valid, output status, output data, output length,
                   output last, input ready);
   modport sink (input valid, input status, input data, input length,
                 input last, output ready);
endinterface

// ===== hw/rtl/indexed_list_engine_top.sv =====
// Top level of the indexed list engine: request decode, chain and response register.
//
//   channel    direction  carries
//   req_chan   in         req_type, value, position
//   rsp_chan   out        status, data, length, last
//
// An insert or delete shifts the whole cell chain in the cycle it is taken, and
// each response is registered at the output. A dump holds the request channel
// while entries remain, one entry a cycle when the response slot is free, as the
// response register drains them through the single read selector.
// Reset clears the length to zero; entry contents stay undefined until written.
// A stalled response holds the output register; a new request is taken in the
// cycle the response is taken.
module indexed_list_engine_top (
   input logic        clock,
   input logic        reset,
   ile_req_if.sink    req_chan,
   ile_rsp_if.source  rsp_chan
);

`include "indexed_list_engine_top_defines.svh"

   // Controller state.
   ile_pkg::fsm_type                 fsm_ff, fsm_in;
   logic [ile_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [ile_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Response payload registers.
   ile_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic signed [ile_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ile_pkg::LEN_W-1:0]        rsp_length_ff, rsp_length_in;
   logic                             rsp_last_ff, rsp_last_in;

   ile_pkg::cell_cmd_type            cmd;
   logic [ile_pkg::IDX_W-1:0]        rd_idx;
   logic signed [ile_pkg::DATA_W-1:0] rd_data;

   ile_pkg::req_kind_type            kind;
   logic                             accept;
   logic                             slot_free;
   logic                             list_empty;
   logic                             list_full;
   logic                             pos_bad;
   logic                             ins_req;
   logic [ile_pkg::CNT_W-1:0]        cnt_m1;
   logic [ile_pkg::IDX_W-1:0]        pos_idx;

   assign kind       = ile_pkg::req_kind_type'(req_chan.req_type);
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (fsm_ff == ile_pkg::FSM_IDLE) && slot_free;
   assign accept     = req_chan.valid && req_chan.ready;
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
   assign cnt_m1     = count_ff - ile_pkg::CNT_W'(1);
   assign pos_idx    = req_chan.position[ile_pkg::IDX_W-1:0];
   assign pos_bad    = ile_pkg::CMP_W'(req_chan.position) >= ile_pkg::CMP_W'(count_ff);
   assign ins_req    = (kind == ile_pkg::REQ_INS_FRONT) || (kind == ile_pkg::REQ_INS_BACK) ||
                       (kind == ile_pkg::REQ_INS_AFTER) || (kind == ile_pkg::REQ_INS_BEFORE);

   // Read address: the dump walker while dumping, the first entry at the start
   // of a dump, the requested position otherwise.
   always_comb begin
      if (fsm_ff == ile_pkg::FSM_DUMP) begin
         rd_idx = idx_ff;
      end else if (kind == ile_pkg::REQ_DUMP) begin
         rd_idx = '0;
      end else begin
         rd_idx = pos_idx;
      end
   end

   ile_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // Request decode, chain command and response formation.
   always_comb begin
      fsm_in        = fsm_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd.op        = ile_pkg::CELL_HOLD;
      cmd.at        = '0;
      cmd.value     = req_chan.value;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_length_in = rsp_length_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      case (fsm_ff)
         ile_pkg::FSM_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ile_pkg::STAT_OK;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               case (kind)
                  ile_pkg::REQ_INS_FRONT, ile_pkg::REQ_INS_BACK,
                  ile_pkg::REQ_INS_AFTER, ile_pkg::REQ_INS_BEFORE: begin
                     if (list_full) begin
                        rsp_status_in = ile_pkg::STAT_FULL;
                     end else if ((kind == ile_pkg::REQ_INS_AFTER ||
                                   kind == ile_pkg::REQ_INS_BEFORE) && pos_bad) begin
                        rsp_status_in = ile_pkg::STAT_RANGE;
                     end else begin
                        cmd.op   = ile_pkg::CELL_INS;
                        count_in = count_ff + ile_pkg::CNT_W'(1);
                        case (kind)
                           ile_pkg::REQ_INS_FRONT: cmd.at = '0;
                           ile_pkg::REQ_INS_BACK:  cmd.at = count_ff[ile_pkg::IDX_W-1:0];
                           ile_pkg::REQ_INS_AFTER: cmd.at = pos_idx + ile_pkg::IDX_W'(1);
                           default:                cmd.at = pos_idx;
                        endcase
                     end
                  end
                  ile_pkg::REQ_DEL_FRONT, ile_pkg::REQ_DEL_BACK,
                  ile_pkg::REQ_DEL_AT, ile_pkg::REQ_READ_AT: begin
                     if (list_empty) begin
                        rsp_status_in = ile_pkg::STAT_EMPTY;
                     end else if ((kind == ile_pkg::REQ_DEL_AT ||
                                   kind == ile_pkg::REQ_READ_AT) && pos_bad) begin
                        rsp_status_in = ile_pkg::STAT_RANGE;
                     end else if (kind == ile_pkg::REQ_READ_AT) begin
                        rsp_data_in = rd_data;
                     end else begin
                        cmd.op   = ile_pkg::CELL_DEL;
                        count_in = cnt_m1;
                        case (kind)
                           ile_pkg::REQ_DEL_FRONT: cmd.at = '0;
                           ile_pkg::REQ_DEL_BACK:  cmd.at = cnt_m1[ile_pkg::IDX_W-1:0];
                           default:                cmd.at = pos_idx;
                        endcase
                     end
                  end
                  ile_pkg::REQ_DUMP: begin
                     if (list_empty) begin
                        rsp_status_in = ile_pkg::STAT_EMPTY;
                     end else begin
                        rsp_data_in = rd_data;
                        if (count_ff != ile_pkg::CNT_W'(1)) begin
                           rsp_last_in = 1'b0;
                           idx_in      = ile_pkg::IDX_W'(1);
                           fsm_in      = ile_pkg::FSM_DUMP;
                        end
                     end
                  end
                  default: begin
                     // Unknown request codes change nothing.
                     rsp_status_in = ile_pkg::STAT_OK;
                  end
               endcase
               rsp_length_in = ile_pkg::LEN_W'(count_in);
            end
         end
         ile_pkg::FSM_DUMP: begin
            // Walk the remaining entries, one per free response slot.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ile_pkg::STAT_OK;
               rsp_data_in   = rd_data;
               rsp_length_in = ile_pkg::LEN_W'(count_ff);
               rsp_last_in   = (idx_ff == cnt_m1[ile_pkg::IDX_W-1:0]);
               idx_in        = idx_ff + ile_pkg::IDX_W'(1);
               if (idx_ff == cnt_m1[ile_pkg::IDX_W-1:0]) begin
                  fsm_in = ile_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            fsm_in = ile_pkg::FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ile_pkg::FSM_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.length = rsp_length_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // Checks on the controller.
   `ILE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= ile_pkg::CNT_W'(ile_pkg::CAPACITY), "list length exceeds capacity")
   `ILE_ASSERT_NOW(a_dump_blocks, fsm_ff == ile_pkg::FSM_DUMP, !req_chan.ready, "request taken during a dump")
   `ILE_ASSERT_NEXT(a_full_ignored, accept && ins_req && list_full, count_ff == $past(count_ff), "insert into a full list changed the length")
   `ILE_ASSERT_NEXT(a_dump_emits, fsm_ff == ile_pkg::FSM_DUMP && slot_free, rsp_valid_ff, "dump slot free but no response loaded")

endmodule

// ===== hw/rtl/ile_cell.sv =====
// One list cell: holds a single entry and shifts with its neighbours.
module ile_cell (
   input  logic                              clock,
   input  logic [ile_pkg::IDX_W-1:0]         cell_idx,
   input  ile_pkg::cell_cmd_type             cmd,
   input  logic signed [ile_pkg::DATA_W-1:0] left_data,
   input  logic signed [ile_pkg::DATA_W-1:0] right_data,
   output logic signed [ile_pkg::DATA_W-1:0] data
);

   logic signed [ile_pkg::DATA_W-1:0] data_ff;
   logic signed [ile_pkg::DATA_W-1:0] data_in;

   // An insert opens a gap at the target and pushes later cells rightwards;
   // a delete pulls every cell from the target onwards one place leftwards.
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         ile_pkg::CELL_INS: begin
            if (cell_idx == cmd.at) begin
               data_in = cmd.value;
            end else if (cell_idx > cmd.at) begin
               data_in = left_data;
            end
         end
         ile_pkg::CELL_DEL: begin
            if (cell_idx >= cmd.at) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Entry storage, no reset needed.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hw/rtl/ile_chain.sv =====
// Row of list cells with a read selector over all entries.
module ile_chain (
   input  logic                              clock,
   input  ile_pkg::cell_cmd_type             cmd,
   input  logic [ile_pkg::IDX_W-1:0]         rd_idx,
   output logic signed [ile_pkg::DATA_W-1:0] rd_data
);

   logic signed [ile_pkg::DATA_W-1:0] cell_data [ile_pkg::CAPACITY];

   // The cells, each wired to its left and right neighbours.
   for (genvar g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
      logic signed [ile_pkg::DATA_W-1:0] left_data;
      logic signed [ile_pkg::DATA_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[g-1];
      end

      if (g == ile_pkg::CAPACITY - 1) begin : g_end
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_data[g+1];
      end

      ile_cell u_cell (
         .clock      (clock),
         .cell_idx   (ile_pkg::IDX_W'(g)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g])
      );
   end

   // AND-OR selector: only the addressed cell contributes to the read data.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
         if (rd_idx == ile_pkg::IDX_W'(i)) begin
            rd_data = rd_data | cell_data[i];
         end
      end
   end

endmodule

// ===== verif/indexed_list_engine_top_test.sv =====
// Self-checking testbench for the indexed list engine: random and directed list requests.
module indexed_list_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ile_pkg::*;

   localparam int RANDOM_ITEMS    = 480;
   localparam int RSP_HOLD_CYCLES = 160;
   localparam int DRAIN_CYCLES    = 16;
   localparam int KIND_MAX        = (1 << KIND_W) - 1;
   localparam int POS_MAX         = (1 << POS_W) - 1;

   // Shapes of the random stimulus.
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_kind_t;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          pos;
      bit                        drain_first;
   } list_req_t;

   typedef struct {
      status_type                status;
      logic signed [DATA_W-1:0]  data;
      logic [LEN_W-1:0]          length;
      logic                      last;
   } list_rsp_t;

   logic clock;
   logic reset;

   ile_req_if req_chan ();
   ile_rsp_if rsp_chan ();

   indexed_list_engine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_req_t pending_reqs[$];
   list_rsp_t expected_rsps[$];
   list_req_t on_bus;

   // Shadow of the list contents as the block should hold them.
   logic signed [DATA_W-1:0] list_model[CAPACITY];
   int list_len;

   // Length the stimulus generator expects, used to aim positions.
   int gen_len;

   int accepted_items;
   int checked_results;
   int mismatches;
   int send_gap;
   int rsp_gap;
   bit rsp_hold;

   // Clock, and every input at a known level from time zero.
   initial begin
      clock = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.req_type = '0;
      req_chan.value = '0;
      req_chan.position = '0;
      rsp_chan.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none at all in a calm stretch.
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_rsp(status_type st, logic signed [DATA_W-1:0] d, logic fin);
      list_rsp_t r;
      r.status = st;
      r.data   = d;
      r.length = LEN_W'(list_len);
      r.last   = fin;
      expected_rsps.push_back(r);
   endfunction

   // Open a slot at index at and store v there.
   function automatic void list_insert(int at, logic signed [DATA_W-1:0] v);
      for (int i = list_len; i > at; i--) list_model[i] = list_model[i-1];
      list_model[at] = v;
      list_len++;
   endfunction

   // Close the slot at index at.
   function automatic void list_remove(int at);
      for (int i = at; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
      list_len--;
   endfunction

   // Update the shadow list for one accepted request and queue its responses.
   function automatic void apply_request(list_req_t r);
      status_type st;
      logic signed [DATA_W-1:0] word;
      st = STAT_OK;
      word = '0;
      case (r.kind)
         REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AFTER, REQ_INS_BEFORE: begin
            if (list_len >= CAPACITY) st = STAT_FULL;
            else if (r.kind == REQ_INS_FRONT) list_insert(0, r.value);
            else if (r.kind == REQ_INS_BACK) list_insert(list_len, r.value);
            else if (int'(r.pos) >= list_len) st = STAT_RANGE;
            else if (r.kind == REQ_INS_AFTER) list_insert(int'(r.pos) + 1, r.value);
            else list_insert(int'(r.pos), r.value);
         end
         REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT, REQ_READ_AT: begin
            if (list_len == 0) st = STAT_EMPTY;
            else if (r.kind == REQ_DEL_FRONT) list_remove(0);
            else if (r.kind == REQ_DEL_BACK) list_remove(list_len - 1);
            else if (int'(r.pos) >= list_len) st = STAT_RANGE;
            else if (r.kind == REQ_DEL_AT) list_remove(int'(r.pos));
            else word = list_model[r.pos];
         end
         REQ_DUMP: begin
            if (list_len == 0) begin
               st = STAT_EMPTY;
            end else begin
               for (int i = 0; i < list_len; i++)
                  push_rsp(STAT_OK, list_model[i], i + 1 == list_len);
               return;
            end
         end
         default: ;
      endcase
      push_rsp(st, word, 1'b1);
   endfunction

   // Append one request to the stimulus and track the length it should leave.
   task automatic queue_req(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                            logic [POS_W-1:0] pos, bit drain);
      list_req_t r;
      r.kind = kind;
      r.value = value;
      r.pos = pos;
      r.drain_first = drain;
      pending_reqs.push_back(r);
      case (kind)
         REQ_INS_FRONT, REQ_INS_BACK:
            if (gen_len < CAPACITY) gen_len++;
         REQ_INS_AFTER, REQ_INS_BEFORE:
            if (gen_len < CAPACITY && int'(pos) < gen_len) gen_len++;
         REQ_DEL_FRONT, REQ_DEL_BACK:
            if (gen_len > 0) gen_len--;
         REQ_DEL_AT:
            if (int'(pos) < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // One random request, its mix of operations set by the phase.
   function automatic list_req_t make_item(phase_kind_t mode, int len);
      list_req_t r;
      int pick;
      pick = $urandom_range(0, 99);
      case (mode)
         PH_FILL:
            if (pick < 85) r.kind = KIND_W'($urandom_range(REQ_INS_FRONT, REQ_INS_BEFORE));
            else if (pick < 93) r.kind = REQ_READ_AT;
            else if (pick < 97) r.kind = REQ_DUMP;
            else r.kind = KIND_W'($urandom_range(REQ_DEL_FRONT, REQ_DEL_AT));
         PH_DRAIN:
            if (pick < 85) r.kind = KIND_W'($urandom_range(REQ_DEL_FRONT, REQ_DEL_AT));
            else if (pick < 93) r.kind = REQ_READ_AT;
            else if (pick < 97) r.kind = REQ_DUMP;
            else r.kind = KIND_W'($urandom_range(REQ_INS_FRONT, REQ_INS_BEFORE));
         PH_MIX:
            if (pick < 4) r.kind = REQ_DUMP;
            else if (pick < 7) r.kind = KIND_W'($urandom_range(REQ_DUMP + 1, KIND_MAX));
            else r.kind = KIND_W'($urandom_range(REQ_INS_FRONT, REQ_READ_AT));
         default:
            r.kind = KIND_W'($urandom_range(0, KIND_MAX));
      endcase
      if (len > 0 && $urandom_range(0, 99) < 85) r.pos = POS_W'($urandom_range(0, len - 1));
      else r.pos = POS_W'($urandom_range(0, POS_MAX));
      case ($urandom_range(0, 15))
         0: r.value = 32'sh7FFF_FFFF;
         1: r.value = 32'sh8000_0000;
         2: r.value = '0;
         3: r.value = -32'sd1;
         default: r.value = $urandom;
      endcase
      r.drain_first = 1'b0;
      return r;
   endfunction

   // Request driver: presents queued transactions, with gaps and drain pauses.
   always @(posedge clock) begin : drive_requests
      list_req_t item;
      bit slot_free;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         slot_free = !req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            apply_request(on_bus);
            accepted_items++;
            slot_free = 1'b1;
            send_gap = rsp_hold ? 0 : pick_gap((accepted_items / 48) % 4 == 3);
         end
         if (slot_free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain_first && expected_rsps.size() != 0
                           && !rsp_hold)) begin
               item = pending_reqs.pop_front();
               on_bus = item;
               req_chan.valid    <= 1'b1;
               req_chan.req_type <= item.kind;
               req_chan.value    <= item.value;
               req_chan.position <= item.pos;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transaction against the oldest expectation.
   always @(posedge clock) begin : check_responses
      list_rsp_t want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked_results++;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: status %0d data %0d length %0d last %0d",
                      rsp_chan.status, rsp_chan.data, rsp_chan.length, rsp_chan.last);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status,
                         rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.data !== want.data) begin
                  $error("data mismatch: expected %0d, actual %0d", want.data, rsp_chan.data);
                  mismatches++;
               end
               if (rsp_chan.length !== want.length) begin
                  $error("length mismatch: expected %0d, actual %0d", want.length,
                         rsp_chan.length);
                  mismatches++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_chan.last);
                  mismatches++;
               end
            end
            rsp_gap = pick_gap((checked_results / 60) % 4 == 2);
         end
         if (rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off mid-run, so the output register fills and the input stalls.
   initial begin : rsp_hold_off
      rsp_hold = 1'b0;
      wait (accepted_items >= 260);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      list_req_t item;
      phase_kind_t mode;
      int random_items;
      int n;
      int extra;
      reset = 1'b1;
      list_len = 0;
      gen_len = 0;
      accepted_items = 0;
      checked_results = 0;
      mismatches = 0;
      random_items = 0;

      // Directed: empty-list errors, bad positions, front/back extremes, unknown codes.
      queue_req(REQ_DUMP, '0, '0, 1'b0);
      queue_req(REQ_DEL_FRONT, '0, '0, 1'b0);
      queue_req(REQ_DEL_BACK, '0, '0, 1'b0);
      queue_req(REQ_DEL_AT, '0, '0, 1'b0);
      queue_req(REQ_READ_AT, '0, '0, 1'b0);
      queue_req(REQ_INS_AFTER, 32'sd5, '0, 1'b0);
      queue_req(REQ_INS_BEFORE, 32'sd6, '0, 1'b0);
      queue_req(REQ_INS_FRONT, 32'sh7FFF_FFFF, 6'd17, 1'b0);
      queue_req(REQ_INS_BACK, 32'sh8000_0000, 6'd40, 1'b0);
      queue_req(REQ_INS_AFTER, -32'sd1, 6'd0, 1'b0);
      queue_req(REQ_INS_BEFORE, 32'sd1, 6'd0, 1'b0);
      queue_req(REQ_INS_BEFORE, 32'sh5555_5555, 6'd2, 1'b0);
      queue_req(REQ_READ_AT, '0, 6'd63, 1'b0);
      queue_req(REQ_READ_AT, '0, 6'd4, 1'b0);
      queue_req(REQ_DEL_AT, '0, 6'd63, 1'b0);
      queue_req(REQ_INS_AFTER, 32'shAAAA_AAAA, 6'd4, 1'b0);
      queue_req(REQ_INS_AFTER, 32'sd9, 6'd6, 1'b0);
      queue_req(REQ_DUMP, '0, '0, 1'b0);
      queue_req(KIND_W'(REQ_DUMP + 1), 32'sd3, 6'd1, 1'b0);
      queue_req(KIND_W'(KIND_MAX), -32'sd1, 6'd63, 1'b0);
      queue_req(REQ_DEL_AT, '0, 6'd2, 1'b0);
      queue_req(REQ_DEL_BACK, '0, '0, 1'b0);
      queue_req(REQ_DEL_FRONT, '0, '0, 1'b0);
      queue_req(REQ_DUMP, '0, '0, 1'b0);

      // Random: fill to full and beyond, drain past empty, mixed runs and noise.
      for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
         mode = phase_kind_t'(ph % 4);
         n = 0;
         extra = 0;
         while (n < 80 && random_items < RANDOM_ITEMS) begin
            item = make_item(mode, gen_len);
            queue_req(item.kind, item.value, item.pos,
                      n == 0 && (ph == 0 || $urandom_range(0, 3) == 0));
            n++;
            random_items++;
            if ((mode == PH_FILL && gen_len == CAPACITY) || (mode == PH_DRAIN && gen_len == 0))
               extra++;
            if (extra >= 4 || (mode == PH_MIX && n >= 40) || (mode == PH_NOISE && n >= 10))
               break;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin : run_limit
      #(40_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
